### sv/weighted_prefix_sum_sampler_assert.svh
// assertion macros shared by the rtl
`ifndef WEIGHTED_PREFIX_SUM_SAMPLER_ASSERT_SVH
`define WEIGHTED_PREFIX_SUM_SAMPLER_ASSERT_SVH

// same-cycle implication, checked outside reset
`define WPSS_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("wpss assertion failed");

// next-cycle implication, checked outside reset
`define WPSS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("wpss assertion failed");

`endif

### sv/wpss_pkg.sv
`timescale 1ns / 1ps
package wpss_pkg;

    localparam int MAX_ENTRIES = 1024;
    localparam int ADDR_W      = $clog2(MAX_ENTRIES);
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
    localparam int SUM_W       = 42;
    localparam int VAL_W       = 32;
    localparam int OP_W        = 2;
    localparam int INDEX_W     = 10;
    localparam int COUNT_W     = 11;
    localparam int STATUS_W    = 2;
    localparam int S_DATA_W    = 2 * VAL_W;
    localparam int M_DATA_W    = 24;

    typedef enum logic [OP_W-1:0] {
        OP_CLEAR  = 2'd0,
        OP_APPEND = 2'd1,
        OP_QUERY  = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_EMPTY = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_THRESH,
        ST_SRCH_ADDR,
        ST_SRCH_CMP,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [SUM_W-1:0]  data;
    } tbl_wr_t;

endpackage

### sv/weighted_prefix_sum_sampler.sv
`timescale 1ns / 1ps
// Weighted sampler over a table of up to 1024 running prefix sums (42 bits each).
// Clear, append and the unused op code pass from EXEC to FINISH, where their result
// is loaded into the output register. A query goes from EXEC through MUL_LO, MUL_HI
// and THRESH into the binary search and then to FINISH. Two passes through one
// shared 32x32 multiplier form the threshold sample*total/2^32. Each binary search
// step then uses the SRCH_ADDR state for the registered table read and SRCH_CMP for
// the compare. The block is ready again in the cycle after a result is loaded. One
// item is in work at a time. The result sits in an output register, so the next
// item is accepted while a result still waits to be taken.
`include "weighted_prefix_sum_sampler_assert.svh"
module weighted_prefix_sum_sampler (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [wpss_pkg::S_DATA_W-1:0]  s_tdata,  // weight[31:0], sample[63:32]
    input  logic [wpss_pkg::OP_W-1:0]      s_tuser,  // op[1:0]
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [wpss_pkg::M_DATA_W-1:0]  m_tdata,  // index[9:0], count[20:10], zero[23:21]
    output logic [wpss_pkg::STATUS_W-1:0]  m_tuser   // status[1:0]
);
    import wpss_pkg::*;

    state_t             state_reg, state_next;
    op_t                op_reg, op_next;
    logic [VAL_W-1:0]   weight_reg, weight_next;
    logic [VAL_W-1:0]   sample_reg, sample_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [SUM_W-1:0]   total_reg, total_next;
    logic [VAL_W-1:0]   frac_reg, frac_next;
    logic [SUM_W-1:0]   thresh_reg, thresh_next;
    logic [ADDR_W-1:0]  lo_reg, lo_next;
    logic [ADDR_W-1:0]  hi_reg, hi_next;
    logic [ADDR_W-1:0]  mid_reg, mid_next;
    logic [INDEX_W-1:0] res_index_reg, res_index_next;
    status_t            res_status_reg, res_status_next;
    logic               m_valid_reg, m_valid_next;
    logic [INDEX_W-1:0] m_index_reg, m_index_next;
    logic [COUNT_W-1:0] m_count_reg, m_count_next;
    status_t            m_status_reg, m_status_next;

    tbl_wr_t            tbl_wr;
    logic [ADDR_W-1:0]  tbl_raddr;
    logic [SUM_W-1:0]   tbl_rdata;
    logic [VAL_W-1:0]   mul_b;
    logic [2*VAL_W-1:0] prod;

    logic               accept;
    logic               out_load;
    logic               table_full;
    logic [SUM_W:0]     sum_wide;
    logic [SUM_W-1:0]   sum_sat;
    logic [ADDR_W-1:0]  mid;
    logic [INDEX_W-1:0] last_index;

    wpss_table u_table (
        .aclk  (aclk),
        .wr    (tbl_wr),
        .raddr (tbl_raddr),
        .rdata (tbl_rdata)
    );

    wpss_mult u_mult (
        .aclk  (aclk),
        .mul_a (sample_reg),
        .mul_b (mul_b),
        .prod  (prod)
    );

    assign table_full = (count_reg >= CNT_W'(MAX_ENTRIES));
    assign sum_wide   = {1'b0, total_reg} + (SUM_W + 1)'(weight_reg);
    assign sum_sat    = sum_wide[SUM_W] ? {SUM_W{1'b1}} : sum_wide[SUM_W-1:0];
    assign mid        = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign last_index = (count_reg != '0) ? INDEX_W'(count_reg - CNT_W'(1)) : '0;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) state_next = ST_EXEC;
            end
            ST_EXEC: begin
                if (op_reg == OP_QUERY && count_reg != '0 && total_reg != '0) begin
                    state_next = ST_MUL_LO;
                end else begin
                    state_next = ST_FINISH;
                end
            end
            ST_MUL_LO:    state_next = ST_MUL_HI;
            ST_MUL_HI:    state_next = ST_THRESH;
            ST_THRESH:    state_next = ST_SRCH_ADDR;
            ST_SRCH_ADDR: begin
                state_next = (lo_reg < hi_reg) ? ST_SRCH_CMP : ST_FINISH;
            end
            ST_SRCH_CMP:  state_next = ST_SRCH_ADDR;
            ST_FINISH: begin
                if (!m_valid_reg || m_tready) state_next = ST_IDLE;
            end
            default:      state_next = ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        s_tready    = 1'b0;
        out_load    = 1'b0;
        tbl_wr.en   = 1'b0;
        tbl_wr.addr = count_reg[ADDR_W-1:0];
        tbl_wr.data = sum_sat;
        tbl_raddr   = mid;
        mul_b       = VAL_W'(total_reg[SUM_W-1:VAL_W]);
        unique case (state_reg)
            ST_IDLE:   s_tready = 1'b1;
            ST_EXEC:   tbl_wr.en = (op_reg == OP_APPEND) && !table_full;
            ST_MUL_LO: mul_b = total_reg[VAL_W-1:0];
            ST_FINISH: out_load = !m_valid_reg || m_tready;
            default: ;
        endcase
    end

    assign accept = s_tvalid && s_tready;

    // datapath
    always_comb begin
        op_next         = op_reg;
        weight_next     = weight_reg;
        sample_next     = sample_reg;
        count_next      = count_reg;
        total_next      = total_reg;
        frac_next       = frac_reg;
        thresh_next     = thresh_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        mid_next        = mid_reg;
        res_index_next  = res_index_reg;
        res_status_next = res_status_reg;

        if (accept) begin
            op_next     = op_t'(s_tuser);
            weight_next = s_tdata[VAL_W-1:0];
            sample_next = s_tdata[2*VAL_W-1:VAL_W];
        end

        case (state_reg)
            ST_EXEC: begin
                res_status_next = STAT_OK;
                res_index_next  = last_index;
                case (op_reg)
                    OP_CLEAR: begin
                        count_next     = '0;
                        total_next     = '0;
                        res_index_next = '0;
                    end
                    OP_APPEND: begin
                        if (table_full) begin
                            res_status_next = STAT_FULL;
                        end else begin
                            total_next     = sum_sat;
                            count_next     = count_reg + CNT_W'(1);
                            res_index_next = INDEX_W'(count_reg);
                        end
                    end
                    OP_QUERY: begin
                        if (count_reg == '0 || total_reg == '0) begin
                            res_status_next = STAT_EMPTY;
                            res_index_next  = '0;
                        end
                    end
                    default: ;
                endcase
            end
            // low product of sample and total is ready now
            ST_MUL_HI: frac_next = prod[2*VAL_W-1:VAL_W];
            ST_THRESH: begin
                thresh_next = prod[SUM_W-1:0] + SUM_W'(frac_reg);
                lo_next     = '0;
                hi_next     = ADDR_W'(count_reg - CNT_W'(1));
            end
            ST_SRCH_ADDR: begin
                mid_next = mid;
                if (lo_reg >= hi_reg) begin
                    res_index_next = INDEX_W'(lo_reg);
                end
            end
            ST_SRCH_CMP: begin
                if (tbl_rdata > thresh_reg) begin
                    hi_next = mid_reg;
                end else begin
                    lo_next = mid_reg + ADDR_W'(1);
                end
            end
            default: ;
        endcase
    end

    // output register
    always_comb begin
        m_valid_next  = m_valid_reg;
        m_index_next  = m_index_reg;
        m_count_next  = m_count_reg;
        m_status_next = m_status_reg;
        if (out_load) begin
            m_valid_next  = 1'b1;
            m_index_next  = res_index_reg;
            m_count_next  = COUNT_W'(count_reg);
            m_status_next = res_status_reg;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            total_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            total_reg   <= total_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg         <= op_next;
        weight_reg     <= weight_next;
        sample_reg     <= sample_next;
        frac_reg       <= frac_next;
        thresh_reg     <= thresh_next;
        lo_reg         <= lo_next;
        hi_reg         <= hi_next;
        mid_reg        <= mid_next;
        res_index_reg  <= res_index_next;
        res_status_reg <= res_status_next;
        m_index_reg    <= m_index_next;
        m_count_reg    <= m_count_next;
        m_status_reg   <= m_status_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {(M_DATA_W - INDEX_W - COUNT_W)'(0), m_count_reg, m_index_reg};
    assign m_tuser  = m_status_reg;

    `WPSS_ASSERT_IMP(a_count_bound, 1'b1, count_reg <= CNT_W'(MAX_ENTRIES))
    `WPSS_ASSERT_IMP(a_thresh_below_total, state_reg == ST_SRCH_ADDR, thresh_reg < total_reg)
    `WPSS_ASSERT_IMP(a_mid_in_range, state_reg == ST_SRCH_CMP, lo_reg <= mid_reg && mid_reg < hi_reg)
    `WPSS_ASSERT_NEXT(a_finish_to_idle, state_reg == ST_FINISH && out_load, m_tvalid && s_tready)

endmodule

### sv/wpss_table.sv
`timescale 1ns / 1ps
module wpss_table (
    input  logic                   aclk,
    input  wpss_pkg::tbl_wr_t      wr,
    input  logic [wpss_pkg::ADDR_W-1:0] raddr,
    output logic [wpss_pkg::SUM_W-1:0]  rdata
);
    import wpss_pkg::*;

    logic [SUM_W-1:0] mem [MAX_ENTRIES];
    logic [SUM_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.addr] <= wr.data;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### sv/wpss_mult.sv
`timescale 1ns / 1ps
module wpss_mult (
    input  logic                          aclk,
    input  logic [wpss_pkg::VAL_W-1:0]    mul_a,
    input  logic [wpss_pkg::VAL_W-1:0]    mul_b,
    output logic [2*wpss_pkg::VAL_W-1:0]  prod
);
    import wpss_pkg::*;

    logic [2*VAL_W-1:0] prod_reg;

    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * mul_b;
    end

    assign prod = prod_reg;

endmodule
